FILE: design/hss_pkg.sv
// ---------------------------------------------------------------------------
// hss_pkg: shared types and constants for the heater safety supervisor
// Holds the command codes, register indexes and the structs that pass
// configuration and supervisor state between the modules.
// ---------------------------------------------------------------------------
package hss_pkg;

  // Command carried in the op field of an input transaction.
  typedef enum logic [1:0] {
    OP_SAMPLE    = 2'd0,
    OP_HEAT_ON   = 2'd1,
    OP_HEAT_OFF  = 2'd2,
    OP_FAULT_CLR = 2'd3
  } op_t;

  // Configuration register indexes.
  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_ADDR_W-1:0] REG_AIR_SETPOINT   = 4'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_BED_SETPOINT   = 4'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_AIR_HYSTERESIS = 4'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_BED_REACH_BAND = 4'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_PROTECT_BAND   = 4'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_AIR_MIN_TEMP   = 4'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_BED_MIN_TEMP   = 4'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_PROTECT_PERIOD = 4'd7;

  // Stream widths.
  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 16;

  // Current configuration as seen by the step logic.
  typedef struct packed {
    logic [11:0]        air_setpoint;
    logic [11:0]        bed_setpoint;
    logic [8:0]         air_hysteresis;
    logic [8:0]         bed_reach_band;
    logic [8:0]         protect_band;
    logic signed [12:0] air_min_temp;
    logic signed [12:0] bed_min_temp;
    logic [15:0]        protect_period;
  } cfg_t;

  // Supervisor state carried from one transaction to the next.
  typedef struct packed {
    logic        heater_running;
    logic        air_reached;
    logic        bed_reached;
    logic        air_fault;
    logic        bed_fault;
    logic        runaway;
    logic        fault_latched;
    logic [15:0] fan_cnt;
    logic [15:0] wd_cnt;
    logic        wd_armed;
  } state_t;

  // Result fields, first field in the highest bit.
  typedef struct packed {
    logic fault_active;
    logic runaway_fault;
    logic bed_sensor_fault;
    logic air_sensor_fault;
    logic bed_reached;
    logic air_reached;
    logic heater_on;
    logic fan_on;
    logic loop_enable;
  } result_t;

endpackage

FILE: design/heater_safety_supervisor.sv
// ---------------------------------------------------------------------------
// heater_safety_supervisor: safety supervisor for a two-sensor heater
// Input transactions carry a command or an air/bed sample; every input
// transaction produces exactly one status transaction on the output.
// ---------------------------------------------------------------------------
// Usage:
//   in_tdata  carries op, air_temp and bed_temp. op 0 is a sample tick,
//   1 turns the heater on, 2 turns it off, 3 clears the latched faults.
//   out_tdata carries nine status bits that show the state after the item.
//   cfg_* writes one of eight registers; the user must write only while the
//   block is idle, as the block does not enforce it; writes are always accepted.
// Pipeline and throughput:
//   An accepted item is held in the input register while the single-pass
//   step logic computes its update; the result is loaded into the output
//   register when the step fires, which needs the output register free, and
//   out_tvalid then rises. One item is accepted per cycle while the output is
//   not stalled; the rate is set by the state update feeding itself.
// Reset and stalls:
//   rst_n (synchronous, active low) restores the register defaults, turns
//   the heater flag on, clears all other flags and counters and empties both
//   stages. When out_tready is low the result is held, the input register
//   keeps its item, and in_tready drops once the input register is full.
// ---------------------------------------------------------------------------
module heater_safety_supervisor
  import hss_pkg::*;
#(
  parameter int unsigned FAN_DELAY_TICKS = 3000
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input stream. tdata, low bit up: op[1:0], air_temp[14:2],
  // bed_temp[27:15], zero fill [31:28].
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // Result stream. tdata, low bit up: loop_enable, fan_on, heater_on,
  // air_reached, bed_reached, air_sensor_fault, bed_sensor_fault,
  // runaway_fault, fault_active, zero fill [15:9].
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  // Configuration write channel.
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t               cfg;
  logic               bed_sp_wr;
  logic               in_valid_r;
  logic [27:0]        in_data_r;
  logic               out_valid_r;
  result_t            out_data_r;
  result_t            res_nxt;
  state_t             state_r;
  state_t             state_nxt;
  state_t             step_state;
  logic               advance;
  op_t                item_op;
  logic signed [12:0] item_air;
  logic signed [12:0] item_bed;

  assign cfg_ready = 1'b1;

  hss_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (cfg_valid),
    .wr_addr   (cfg_addr),
    .wr_data   (cfg_data),
    .cfg       (cfg),
    .bed_sp_wr (bed_sp_wr)
  );

  // Handshake: the step fires when an item is held and the output is free.
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_data_r <= in_tdata[27:0];
    end
  end

  assign item_op  = op_t'(in_data_r[1:0]);
  assign item_air = $signed(in_data_r[14:2]);
  assign item_bed = $signed(in_data_r[27:15]);

  hss_step #(
    .FAN_DELAY_TICKS (FAN_DELAY_TICKS)
  ) u_step (
    .cur      (state_r),
    .cfg      (cfg),
    .op       (item_op),
    .air_temp (item_air),
    .bed_temp (item_bed),
    .nxt      (step_state)
  );

  // Next state: the step result, then a bed setpoint write drops tracking.
  always_comb begin
    state_nxt = advance ? step_state : state_r;
    if (bed_sp_wr) begin
      state_nxt.bed_reached = 1'b0;
      state_nxt.wd_armed    = 1'b0;
      state_nxt.wd_cnt      = 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.heater_running <= 1'b1;
      state_r.air_reached    <= 1'b0;
      state_r.bed_reached    <= 1'b0;
      state_r.air_fault      <= 1'b0;
      state_r.bed_fault      <= 1'b0;
      state_r.runaway        <= 1'b0;
      state_r.fault_latched  <= 1'b0;
      state_r.fan_cnt        <= 16'd0;
      state_r.wd_cnt         <= 16'd0;
      state_r.wd_armed       <= 1'b0;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Status fields of the updated state.
  always_comb begin
    res_nxt.loop_enable      = step_state.heater_running && !step_state.air_reached;
    res_nxt.fan_on           = step_state.fan_cnt != 16'd0;
    res_nxt.heater_on        = step_state.heater_running;
    res_nxt.air_reached      = step_state.air_reached;
    res_nxt.bed_reached      = step_state.bed_reached;
    res_nxt.air_sensor_fault = step_state.air_fault;
    res_nxt.bed_sensor_fault = step_state.bed_fault;
    res_nxt.runaway_fault    = step_state.runaway;
    res_nxt.fault_active     = step_state.fault_latched;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - $bits(result_t)){1'b0}}, out_data_r};

endmodule

FILE: design/hss_cfg_regs.sv
// ---------------------------------------------------------------------------
// hss_cfg_regs: configuration register file
// Decodes writes on the configuration channel into the eight registers and
// flags a bed setpoint write so the supervisor can drop its bed tracking.
// ---------------------------------------------------------------------------
module hss_cfg_regs
  import hss_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [CFG_ADDR_W-1:0] wr_addr,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                  cfg,
  output logic                  bed_sp_wr
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;
  logic bed_sp_hit;

  // Register decode; writes beyond the last register are dropped.
  always_comb begin
    cfg_nxt    = cfg_r;
    bed_sp_hit = 1'b0;
    if (wr_en) begin
      unique case (wr_addr)
        REG_AIR_SETPOINT:   cfg_nxt.air_setpoint   = wr_data[11:0];
        REG_BED_SETPOINT: begin
          cfg_nxt.bed_setpoint = wr_data[11:0];
          bed_sp_hit           = 1'b1;
        end
        REG_AIR_HYSTERESIS: cfg_nxt.air_hysteresis = wr_data[8:0];
        REG_BED_REACH_BAND: cfg_nxt.bed_reach_band = wr_data[8:0];
        REG_PROTECT_BAND:   cfg_nxt.protect_band   = wr_data[8:0];
        REG_AIR_MIN_TEMP:   cfg_nxt.air_min_temp   = $signed(wr_data[12:0]);
        REG_BED_MIN_TEMP:   cfg_nxt.bed_min_temp   = $signed(wr_data[12:0]);
        REG_PROTECT_PERIOD: cfg_nxt.protect_period = wr_data[15:0];
        default: ;
      endcase
    end
  end

  // Register storage with reset defaults.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.air_setpoint   <= 12'd400;
      cfg_r.bed_setpoint   <= 12'd1000;
      cfg_r.air_hysteresis <= 9'd20;
      cfg_r.bed_reach_band <= 9'd20;
      cfg_r.protect_band   <= 9'd100;
      cfg_r.air_min_temp   <= 13'sd0;
      cfg_r.bed_min_temp   <= 13'sd0;
      cfg_r.protect_period <= 16'd6000;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg       = cfg_r;
  assign bed_sp_wr = bed_sp_hit;

endmodule

FILE: design/hss_step.sv
// ---------------------------------------------------------------------------
// hss_step: supervisor update for one transaction
// Computes the next supervisor state from the current state, the
// configuration and one command or sample, in a single pass of logic.
// ---------------------------------------------------------------------------
module hss_step
  import hss_pkg::*;
#(
  parameter int unsigned FAN_DELAY_TICKS = 3000
) (
  input  state_t             cur,
  input  cfg_t               cfg,
  input  op_t                op,
  input  logic signed [12:0] air_temp,
  input  logic signed [12:0] bed_temp,
  output state_t             nxt
);

  localparam logic [15:0] FanLoad = 16'(FAN_DELAY_TICKS);

  logic signed [13:0] air_ext;
  logic signed [13:0] bed_ext;
  logic signed [13:0] air_sp_ext;
  logic signed [13:0] bed_sp_ext;
  logic signed [13:0] air_low_thr;
  logic signed [14:0] bed_diff;
  logic [13:0]        bed_diff_abs;
  logic               near_reach;
  logic               near_protect;
  logic [15:0]        wd_inc;

  // Operand extension and the bed distance, shared by several rules.
  always_comb begin
    air_ext      = {air_temp[12], air_temp};
    bed_ext      = {bed_temp[12], bed_temp};
    air_sp_ext   = $signed({2'b00, cfg.air_setpoint});
    bed_sp_ext   = $signed({2'b00, cfg.bed_setpoint});
    air_low_thr  = air_sp_ext - $signed({5'b00000, cfg.air_hysteresis});
    bed_diff     = {bed_sp_ext[13], bed_sp_ext} - {bed_ext[13], bed_ext};
    bed_diff_abs = bed_diff[14] ? 14'(-bed_diff) : bed_diff[13:0];
    near_reach   = bed_diff_abs < {5'b00000, cfg.bed_reach_band};
    near_protect = bed_diff_abs < {5'b00000, cfg.protect_band};
    wd_inc       = cur.wd_cnt + 16'd1;
  end

  // Rules applied in order; later rules see the effect of earlier ones.
  always_comb begin
    nxt = cur;
    case (op)
      OP_SAMPLE: begin
        // Heating-loss watchdog tick.
        if (cur.wd_armed) begin
          nxt.wd_cnt = wd_inc;
          if (wd_inc >= cfg.protect_period) begin
            nxt.runaway        = 1'b1;
            nxt.heater_running = 1'b0;
            nxt.wd_armed       = 1'b0;
            nxt.wd_cnt         = 16'd0;
          end
        end
        // Fan off-delay.
        if (nxt.heater_running || (bed_ext > bed_sp_ext)) begin
          nxt.fan_cnt = FanLoad;
        end else if (cur.fan_cnt != 16'd0) begin
          nxt.fan_cnt = cur.fan_cnt - 16'd1;
        end
        // Low-reading sensor faults.
        if (air_temp < cfg.air_min_temp) begin
          nxt.air_fault      = 1'b1;
          nxt.heater_running = 1'b0;
        end
        if (bed_temp < cfg.bed_min_temp) begin
          nxt.bed_fault      = 1'b1;
          nxt.heater_running = 1'b0;
        end
        // Air hysteresis.
        if (air_ext >= air_sp_ext) begin
          nxt.air_reached = 1'b1;
        end
        if (air_ext < air_low_thr) begin
          nxt.air_reached = 1'b0;
        end
        // Loop gate.
        if (nxt.heater_running && !nxt.air_reached) begin
          if (near_reach) begin
            nxt.bed_reached = 1'b1;
          end
        end else begin
          nxt.bed_reached = 1'b0;
          nxt.wd_armed    = 1'b0;
          nxt.wd_cnt      = 16'd0;
        end
        // Watchdog re-arm.
        if (nxt.bed_reached && near_protect) begin
          nxt.wd_armed = 1'b1;
          nxt.wd_cnt   = 16'd0;
        end
        // Fault latch.
        if (nxt.air_fault || nxt.bed_fault || nxt.runaway) begin
          nxt.fault_latched = 1'b1;
        end
      end
      OP_HEAT_ON:  nxt.heater_running = 1'b1;
      OP_HEAT_OFF: nxt.heater_running = 1'b0;
      default: begin
        nxt.air_fault     = 1'b0;
        nxt.bed_fault     = 1'b0;
        nxt.runaway       = 1'b0;
        nxt.fault_latched = 1'b0;
        nxt.bed_reached   = 1'b0;
      end
    endcase
  end

endmodule

FILE: tb/sv/hss_status_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hss_status_checker: status predictor and scoreboard for the supervisor
// Watches the configuration, input and result channels of the heater safety
// supervisor. It keeps its own copy of the registers and the supervisor
// state, works out the status that each accepted input transaction must
// produce, and compares every result transaction field by field with the
// oldest expected status.
// ---------------------------------------------------------------------------
module hss_status_checker
  import hss_pkg::*;
#(
  parameter int unsigned FAN_DELAY_TICKS = 3000
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatch_count,
  output int                    outstanding
);

  localparam logic [15:0] FAN_LOAD = 16'(FAN_DELAY_TICKS);

  cfg_t    cfg;
  state_t  st;
  result_t expected_status [$];
  int      mismatches = 0;
  int      waiting = 0;
  int      result_index = 0;

  assign mismatch_count = mismatches;
  assign outstanding    = waiting;

  // Count one differing status bit and report the first few.
  function automatic void compare_field(string name, logic want, logic got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result %0d: %s expected %b, got %b", result_index, name, want, got);
    end
  endfunction

  // Advance the supervisor state by one input item and return its status.
  function automatic result_t predict_status(logic [IN_DATA_W-1:0] item);
    op_t     op;
    int      air;
    int      bed;
    int      air_sp;
    int      bed_sp;
    int      bed_dist;
    result_t r;
    op       = op_t'(item[1:0]);
    air      = $signed(item[14:2]);
    bed      = $signed(item[27:15]);
    air_sp   = int'(cfg.air_setpoint);
    bed_sp   = int'(cfg.bed_setpoint);
    bed_dist = (bed_sp > bed) ? bed_sp - bed : bed - bed_sp;
    case (op)
      OP_SAMPLE: begin
        // Heating-loss watchdog; a period of zero fires on the first tick.
        if (st.wd_armed) begin
          st.wd_cnt = st.wd_cnt + 16'd1;
          if (st.wd_cnt >= cfg.protect_period) begin
            st.runaway        = 1'b1;
            st.heater_running = 1'b0;
            st.wd_armed       = 1'b0;
            st.wd_cnt         = '0;
          end
        end
        // Fan off-delay: reloaded while heating or while the bed is hot.
        if (st.heater_running || bed > bed_sp) begin
          st.fan_cnt = FAN_LOAD;
        end else if (st.fan_cnt != 16'd0) begin
          st.fan_cnt = st.fan_cnt - 16'd1;
        end
        // Low readings latch a sensor fault and stop the heater.
        if (air < $signed(cfg.air_min_temp)) begin
          st.air_fault      = 1'b1;
          st.heater_running = 1'b0;
        end
        if (bed < $signed(cfg.bed_min_temp)) begin
          st.bed_fault      = 1'b1;
          st.heater_running = 1'b0;
        end
        // Air hysteresis.
        if (air >= air_sp) st.air_reached = 1'b1;
        if (air < air_sp - int'(cfg.air_hysteresis)) st.air_reached = 1'b0;
        // Loop gate and bed-reached latch.
        if (st.heater_running && !st.air_reached) begin
          if (bed_dist < int'(cfg.bed_reach_band)) st.bed_reached = 1'b1;
        end else begin
          st.bed_reached = 1'b0;
          st.wd_armed    = 1'b0;
          st.wd_cnt      = '0;
        end
        // Re-arm the watchdog while the bed holds near its setpoint.
        if (st.bed_reached && bed_dist < int'(cfg.protect_band)) begin
          st.wd_armed = 1'b1;
          st.wd_cnt   = '0;
        end
        if (st.air_fault || st.bed_fault || st.runaway) st.fault_latched = 1'b1;
      end
      OP_HEAT_ON:  st.heater_running = 1'b1;
      OP_HEAT_OFF: st.heater_running = 1'b0;
      OP_FAULT_CLR: begin
        st.air_fault     = 1'b0;
        st.bed_fault     = 1'b0;
        st.runaway       = 1'b0;
        st.fault_latched = 1'b0;
        st.bed_reached   = 1'b0;
      end
    endcase
    r.loop_enable      = st.heater_running && !st.air_reached;
    r.fan_on           = st.fan_cnt != 16'd0;
    r.heater_on        = st.heater_running;
    r.air_reached      = st.air_reached;
    r.bed_reached      = st.bed_reached;
    r.air_sensor_fault = st.air_fault;
    r.bed_sensor_fault = st.bed_fault;
    r.runaway_fault    = st.runaway;
    r.fault_active     = st.fault_latched;
    return r;
  endfunction

  // Track register writes, check result transactions, queue predictions.
  always @(posedge clk) begin : track_status
    result_t got;
    result_t want;
    if (!rst_n) begin
      cfg.air_setpoint   = 12'd400;
      cfg.bed_setpoint   = 12'd1000;
      cfg.air_hysteresis = 9'd20;
      cfg.bed_reach_band = 9'd20;
      cfg.protect_band   = 9'd100;
      cfg.air_min_temp   = '0;
      cfg.bed_min_temp   = '0;
      cfg.protect_period = 16'd6000;
      st                 = '0;
      st.heater_running  = 1'b1;
      expected_status.delete();
      waiting <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_addr)
          REG_AIR_SETPOINT:   cfg.air_setpoint   = cfg_data[11:0];
          REG_BED_SETPOINT: begin
            // A new bed target restarts the reach latch and the watchdog.
            cfg.bed_setpoint = cfg_data[11:0];
            st.bed_reached   = 1'b0;
            st.wd_armed      = 1'b0;
            st.wd_cnt        = '0;
          end
          REG_AIR_HYSTERESIS: cfg.air_hysteresis = cfg_data[8:0];
          REG_BED_REACH_BAND: cfg.bed_reach_band = cfg_data[8:0];
          REG_PROTECT_BAND:   cfg.protect_band   = cfg_data[8:0];
          REG_AIR_MIN_TEMP:   cfg.air_min_temp   = cfg_data[12:0];
          REG_BED_MIN_TEMP:   cfg.bed_min_temp   = cfg_data[12:0];
          REG_PROTECT_PERIOD: cfg.protect_period = cfg_data;
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got = result_t'(out_tdata[8:0]);
        result_index++;
        if (expected_status.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: status %b arrived with nothing expected",
                     result_index, got);
        end else begin
          want = expected_status.pop_front();
          compare_field("loop_enable", want.loop_enable, got.loop_enable);
          compare_field("fan_on", want.fan_on, got.fan_on);
          compare_field("heater_on", want.heater_on, got.heater_on);
          compare_field("air_reached", want.air_reached, got.air_reached);
          compare_field("bed_reached", want.bed_reached, got.bed_reached);
          compare_field("air_sensor_fault", want.air_sensor_fault, got.air_sensor_fault);
          compare_field("bed_sensor_fault", want.bed_sensor_fault, got.bed_sensor_fault);
          compare_field("runaway_fault", want.runaway_fault, got.runaway_fault);
          compare_field("fault_active", want.fault_active, got.fault_active);
        end
      end
      if (in_tvalid && in_tready) expected_status.push_back(predict_status(in_tdata));
      waiting <= expected_status.size();
    end
  end

endmodule

FILE: tb/sv/heater_safety_supervisor_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// heater_safety_supervisor_test: stimulus and verdict for the supervisor
// Drives a short directed sequence through the fault, hysteresis, reach and
// watchdog corners, then random sample episodes under several register
// settings and idling patterns, including one long result hold-off. The
// status checker beside the block predicts and compares every result.
// ---------------------------------------------------------------------------
module heater_safety_supervisor_test
  import hss_pkg::*;
();

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 1050;
  localparam int PHASES       = 6;
  localparam int HOLD_CYCLES  = 300;
  localparam int FAN_DELAY    = 3000;
  localparam int TEMP_MIN     = -550;
  localparam int TEMP_MAX     = 3000;
  localparam logic [CFG_ADDR_W-1:0] REG_UNMAPPED = 4'd11;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_ADDR_W-1:0] cfg_addr   = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  int   mismatch_count;
  int   outstanding;
  int   cycle_count        = 0;
  int   items_sent         = 0;
  int   sender_idle_pct    = 0;
  int   receiver_stall_pct = 0;
  logic hold_req           = 1'b0;
  logic hold_ack           = 1'b0;
  int   hold_left          = 0;

  // Current targets, used to aim the samples at the interesting bands.
  int air_sp, bed_sp, air_hyst, reach_band, prot_band;

  heater_safety_supervisor #(
    .FAN_DELAY_TICKS(FAN_DELAY)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data)
  );

  hss_status_checker #(
    .FAN_DELAY_TICKS(FAN_DELAY)
  ) status_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_addr      (cfg_addr),
    .cfg_data      (cfg_data),
    .mismatch_count(mismatch_count),
    .outstanding   (outstanding)
  );

  // 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Result side: random stalls, plus a long hold-off on request.
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack   <= hold_req;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end
  end

  function automatic int clamp_temp(int v);
    return (v < TEMP_MIN) ? TEMP_MIN : ((v > TEMP_MAX) ? TEMP_MAX : v);
  endfunction

  function automatic int any_temp();
    return int'($urandom_range(0, TEMP_MAX - TEMP_MIN)) + TEMP_MIN;
  endfunction

  // Offer one input transaction and wait until it is taken.
  task automatic send_item(input op_t op, input int air, input int bed);
    logic [12:0] air_bits;
    logic [12:0] bed_bits;
    air_bits = air[12:0];
    bed_bits = bed[12:0];
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0000, bed_bits, air_bits, op};
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  // One register write; the caller lowers cfg_valid after the last one.
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input int value);
    cfg_valid <= 1'b1;
    cfg_addr  <= addr;
    cfg_data  <= value[15:0];
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Stop offering and wait until every expected status has come back.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Load a full register set while the block is idle.
  task automatic configure(input int a_sp, input int b_sp, input int hyst,
                           input int reach, input int pband, input int a_min,
                           input int b_min, input int period);
    drain();
    air_sp     = a_sp;
    bed_sp     = b_sp;
    air_hyst   = hyst;
    reach_band = reach;
    prot_band  = pband;
    write_reg(REG_AIR_SETPOINT, a_sp);
    write_reg(REG_BED_SETPOINT, b_sp);
    write_reg(REG_AIR_HYSTERESIS, hyst);
    write_reg(REG_BED_REACH_BAND, reach);
    write_reg(REG_PROTECT_BAND, pband);
    write_reg(REG_AIR_MIN_TEMP, a_min);
    write_reg(REG_BED_MIN_TEMP, b_min);
    write_reg(REG_PROTECT_PERIOD, period);
    // A write to an unmapped index must change nothing.
    write_reg(REG_UNMAPPED, int'($urandom_range(0, 65535)));
    cfg_valid <= 1'b0;
  endtask

  // A heating run: restart the heater, settle the bed near its target,
  // then let it drift out of the protect band so the watchdog can expire.
  task automatic run_episode();
    int n;
    int pick;
    int air;
    int bed;
    int offset;
    if ($urandom_range(0, 3) == 0) send_item(OP_FAULT_CLR, any_temp(), any_temp());
    send_item(OP_HEAT_ON, any_temp(), any_temp());
    n = $urandom_range(4, 24);
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        send_item(op_t'($urandom_range(0, 3)), any_temp(), any_temp());
      end else if (pick < 20) begin
        send_item(OP_SAMPLE, any_temp(), any_temp());
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 75)
          air = air_sp - air_hyst - int'($urandom_range(1, 300));
        else if (pick < 90)
          air = air_sp - air_hyst + int'($urandom_range(0, air_hyst + 20));
        else
          air = any_temp();
        if (i < n / 3 || $urandom_range(0, 3) == 0) begin
          bed = bed_sp + int'($urandom_range(0, 2 * reach_band)) - reach_band;
        end else begin
          offset = prot_band + int'($urandom_range(0, 100));
          bed = ($urandom_range(0, 1) != 0) ? bed_sp + offset : bed_sp - offset;
        end
        send_item(OP_SAMPLE, clamp_temp(air), clamp_temp(bed));
      end
    end
  endtask

  initial begin
    int target;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: commands, reading extremes, fault latching and clearing.
    configure(400, 1000, 20, 20, 100, 0, 0, 6000);
    send_item(OP_HEAT_OFF, 0, 0);
    send_item(OP_SAMPLE, 0, 0);                 // heater off: fan never starts
    send_item(OP_HEAT_ON, 0, 0);
    send_item(OP_SAMPLE, 0, 0);                 // readings exactly at minimum
    send_item(OP_SAMPLE, TEMP_MIN, TEMP_MIN);   // both sensor faults
    send_item(OP_HEAT_ON, 0, 0);                // heater on with faults latched
    send_item(OP_SAMPLE, TEMP_MIN, TEMP_MAX);   // fault still present, hot bed
    send_item(OP_FAULT_CLR, TEMP_MAX, TEMP_MIN);
    send_item(OP_HEAT_ON, TEMP_MAX, TEMP_MAX);
    // Air hysteresis edges, then bed reach and watchdog arming.
    send_item(OP_SAMPLE, TEMP_MAX, TEMP_MAX);
    send_item(OP_SAMPLE, 390, 1000);
    send_item(OP_SAMPLE, 380, 1000);
    send_item(OP_SAMPLE, 379, 1000);
    send_item(OP_SAMPLE, 0, 1019);
    send_item(OP_FAULT_CLR, 0, 0);              // clears the reach latch only
    send_item(OP_SAMPLE, 0, 1099);
    // Zero watchdog period: runaway on the first tick after arming.
    configure(400, 1000, 20, 20, 100, 0, 0, 0);
    send_item(OP_SAMPLE, 0, 1000);
    send_item(OP_SAMPLE, 0, 1000);
    send_item(OP_FAULT_CLR, 0, 0);
    send_item(OP_HEAT_ON, 0, 0);
    send_item(OP_SAMPLE, 0, 981);
    send_item(OP_HEAT_OFF, 0, 0);
    send_item(OP_SAMPLE, 0, 1000);

    // Random episodes under several settings and idling patterns.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: configure(400, 1000, 20, 20, 100, 0, 0, 8);
        1: configure(0, 0, 0, 0, 0, TEMP_MIN, TEMP_MIN, 0);
        2: configure(3000, 3000, 500, 500, 500, TEMP_MAX, TEMP_MAX, 65535);
        3: configure(1500, 2200, 37, 45, 150, -200, 100, 3);
        4: configure(250, 600, 500, 300, 60, TEMP_MIN, TEMP_MIN, 1);
        default: configure(int'($urandom_range(0, 3000)), int'($urandom_range(0, 3000)),
                           int'($urandom_range(0, 500)), int'($urandom_range(0, 500)),
                           int'($urandom_range(0, 500)),
                           int'($urandom_range(0, 1000)) + TEMP_MIN,
                           int'($urandom_range(0, 1000)) + TEMP_MIN,
                           int'($urandom_range(1, 20)));
      endcase
      case (p % 4)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 48; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 48; end
        default: begin sender_idle_pct = 32; receiver_stall_pct = 32; end
      endcase
      // Back-pressure: results held off while the sender keeps pushing.
      if (p == 4) hold_req <= ~hold_req;
      target = items_sent + RANDOM_ITEMS / PHASES;
      while (items_sent < target) run_episode();
    end

    drain();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
